// ===== hdl/fmbq_pkg.sv =====
// Shared types and codes for the front/middle/back queue.
// Holds request and result structs, op codes and status codes.
// No dependencies.
package fmbq_pkg;

  localparam int DATA_W       = 32;
  localparam int OP_W         = 3;
  localparam int ST_W         = 2;
  localparam int CAPACITY_DEF = 64;

  localparam logic [OP_W-1:0] OP_PUSH_FRONT  = 3'd0;
  localparam logic [OP_W-1:0] OP_PUSH_MIDDLE = 3'd1;
  localparam logic [OP_W-1:0] OP_PUSH_BACK   = 3'd2;
  localparam logic [OP_W-1:0] OP_POP_FRONT   = 3'd3;
  localparam logic [OP_W-1:0] OP_POP_MIDDLE  = 3'd4;
  localparam logic [OP_W-1:0] OP_POP_BACK    = 3'd5;

  localparam logic [ST_W-1:0] ST_OK    = 2'd0;
  localparam logic [ST_W-1:0] ST_EMPTY = 2'd1;
  localparam logic [ST_W-1:0] ST_FULL  = 2'd2;

  localparam logic signed [DATA_W-1:0] EMPTY_VALUE = -32'sd1;

  typedef struct packed {
    logic [OP_W-1:0]          op;
    logic signed [DATA_W-1:0] value;
  } fmbq_in_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] popped_value;
    logic [ST_W-1:0]          status;
  } fmbq_out_t;

endpackage

// ===== hdl/fmbq_ram.sv =====
// Simple dual-port RAM: one write port, one read port with registered data.
// Holds one half of the queue as a ring. Depends on nothing.
module fmbq_ram #(
  parameter int DEPTH = 32,
  parameter int WIDTH = 32,
  parameter int AW    = 5
) (
  input  logic             clk,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Hold read data until the next read.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== hdl/front_middle_back_queue_top.sv =====
// Front/middle/back queue: two ring RAMs (front half, back half) with
// head/count registers and a two-step read-then-write sequencer.
// Depends on fmbq_pkg and fmbq_ram.
//
//   channel | direction | handshake           | payload
//   --------+-----------+---------------------+---------------------------
//   in_     | request   | in_valid / in_stall | fmbq_in_t  (op, value)
//   out_    | result    | out_valid/out_stall | fmbq_out_t (popped_value, status)
//
// Each request runs in two steps: the accept in S_IDLE issues one read to each
// ring RAM; S_EXEC, once the result register is free, writes back at most one
// entry per RAM, updates heads and counts and loads the result register.
// Reset is synchronous, active low, and clears heads, counts and handshake
// state; RAM contents are left as they are.
// A held result register stalls only the write-back cycle; a new request is
// taken while a finished result still waits.
module front_middle_back_queue_top #(
  parameter int CAPACITY = fmbq_pkg::CAPACITY_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  fmbq_pkg::fmbq_in_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output fmbq_pkg::fmbq_out_t out_data
);

  import fmbq_pkg::*;

  localparam int HALF_DEPTH = (CAPACITY + 1) / 2;
  localparam int AW         = (HALF_DEPTH > 1) ? $clog2(HALF_DEPTH) : 1;
  localparam int CW         = $clog2(HALF_DEPTH + 1);
  localparam int SW         = CW + 1;
  localparam int TW         = $clog2(CAPACITY + 1);

  typedef enum logic {
    S_IDLE,
    S_EXEC
  } state_t;

  function automatic logic [AW-1:0] wrap_sum(input logic [SW-1:0] s);
    logic [SW-1:0] r;
    r = s;
    if (s >= SW'(HALF_DEPTH)) begin
      r = s - SW'(HALF_DEPTH);
    end
    return r[AW-1:0];
  endfunction

  function automatic logic [AW-1:0] ptr_dec(input logic [AW-1:0] p);
    return (p == '0) ? AW'(HALF_DEPTH - 1) : p - AW'(1);
  endfunction

  function automatic logic [AW-1:0] ptr_inc(input logic [AW-1:0] p);
    return (p == AW'(HALF_DEPTH - 1)) ? '0 : p + AW'(1);
  endfunction

  state_t                   state_r, state_nxt;
  logic [OP_W-1:0]          op_r, op_nxt;
  logic signed [DATA_W-1:0] value_r, value_nxt;
  logic [AW-1:0]            fh_r, fh_nxt, bh_r, bh_nxt;
  logic [CW-1:0]            fc_r, fc_nxt, bc_r, bc_nxt;
  logic                     out_valid_r, out_valid_nxt;
  fmbq_out_t                out_r, out_nxt;

  logic                     accept, finish;
  logic [TW-1:0]            total;
  logic                     eq, full, empty;
  logic [AW-1:0]            f_tail, f_last, f_prev, fh_inc;
  logic [AW-1:0]            b_tail, b_last, b_prev, bh_inc;

  logic                     f_rd_en, b_rd_en;
  logic [AW-1:0]            f_rd_addr, b_rd_addr;
  logic [DATA_W-1:0]        f_rd_data, b_rd_data;
  logic                     f_wr_en, b_wr_en;
  logic [AW-1:0]            f_wr_addr, b_wr_addr;
  logic [DATA_W-1:0]        f_wr_data, b_wr_data;
  fmbq_out_t                res;

  fmbq_ram #(.DEPTH(HALF_DEPTH), .WIDTH(DATA_W), .AW(AW)) u_front_ram (
    .clk     (clk),
    .rd_en   (f_rd_en),
    .rd_addr (f_rd_addr),
    .rd_data (f_rd_data),
    .wr_en   (f_wr_en),
    .wr_addr (f_wr_addr),
    .wr_data (f_wr_data)
  );

  fmbq_ram #(.DEPTH(HALF_DEPTH), .WIDTH(DATA_W), .AW(AW)) u_back_ram (
    .clk     (clk),
    .rd_en   (b_rd_en),
    .rd_addr (b_rd_addr),
    .rd_data (b_rd_data),
    .wr_en   (b_wr_en),
    .wr_addr (b_wr_addr),
    .wr_data (b_wr_data)
  );

  assign in_stall  = (state_r != S_IDLE);
  assign accept    = in_valid && !in_stall;
  assign finish    = (state_r == S_EXEC) && (!out_valid_r || !out_stall);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  assign total = TW'(fc_r) + TW'(bc_r);
  assign eq    = (fc_r == bc_r);
  assign full  = (total >= TW'(CAPACITY));
  assign empty = (total == '0);

  assign f_tail = wrap_sum(SW'(fh_r) + SW'(fc_r));
  assign f_last = wrap_sum(SW'(fh_r) + SW'(fc_r) - SW'(1));
  assign f_prev = ptr_dec(fh_r);
  assign fh_inc = ptr_inc(fh_r);
  assign b_tail = wrap_sum(SW'(bh_r) + SW'(bc_r));
  assign b_last = wrap_sum(SW'(bh_r) + SW'(bc_r) - SW'(1));
  assign b_prev = ptr_dec(bh_r);
  assign bh_inc = ptr_inc(bh_r);

  // Read both boundary candidates as the request is taken.
  assign f_rd_en   = accept;
  assign b_rd_en   = accept;
  assign f_rd_addr = (in_data.op == OP_POP_FRONT) ? fh_r : f_last;
  assign b_rd_addr = (in_data.op == OP_POP_BACK) ? b_last : bh_r;

  always_comb begin
    fh_nxt           = fh_r;
    fc_nxt           = fc_r;
    bh_nxt           = bh_r;
    bc_nxt           = bc_r;
    f_wr_en          = 1'b0;
    f_wr_addr        = f_tail;
    f_wr_data        = value_r;
    b_wr_en          = 1'b0;
    b_wr_addr        = b_tail;
    b_wr_data        = value_r;
    res.popped_value = '0;
    res.status       = ST_OK;

    if (finish) begin
      unique case (op_r)
        OP_PUSH_FRONT: begin
          if (full) begin
            res.status = ST_FULL;
          end else if (eq && fc_r == '0) begin
            b_wr_en   = 1'b1;
            b_wr_addr = b_prev;
            bh_nxt    = b_prev;
            bc_nxt    = bc_r + CW'(1);
          end else if (eq) begin
            // Move the last front entry over, then push in front.
            b_wr_en   = 1'b1;
            b_wr_addr = b_prev;
            b_wr_data = f_rd_data;
            bh_nxt    = b_prev;
            bc_nxt    = bc_r + CW'(1);
            f_wr_en   = 1'b1;
            f_wr_addr = f_prev;
            fh_nxt    = f_prev;
          end else begin
            f_wr_en   = 1'b1;
            f_wr_addr = f_prev;
            fh_nxt    = f_prev;
            fc_nxt    = fc_r + CW'(1);
          end
        end
        OP_PUSH_MIDDLE: begin
          if (full) begin
            res.status = ST_FULL;
          end else if (eq) begin
            b_wr_en   = 1'b1;
            b_wr_addr = b_prev;
            bh_nxt    = b_prev;
            bc_nxt    = bc_r + CW'(1);
          end else begin
            f_wr_en = 1'b1;
            fc_nxt  = fc_r + CW'(1);
          end
        end
        OP_PUSH_BACK: begin
          if (full) begin
            res.status = ST_FULL;
          end else if (eq) begin
            b_wr_en = 1'b1;
            bc_nxt  = bc_r + CW'(1);
          end else begin
            // First back entry moves to the front tail; new entry lands at
            // the old back tail.
            f_wr_en   = 1'b1;
            f_wr_data = b_rd_data;
            fc_nxt    = fc_r + CW'(1);
            b_wr_en   = 1'b1;
            bh_nxt    = bh_inc;
          end
        end
        OP_POP_FRONT: begin
          if (empty) begin
            res.popped_value = EMPTY_VALUE;
            res.status       = ST_EMPTY;
          end else if (eq) begin
            res.popped_value = f_rd_data;
            fh_nxt           = fh_inc;
            fc_nxt           = fc_r - CW'(1);
          end else if (fc_r == '0) begin
            // Entry passes through the empty front half.
            res.popped_value = b_rd_data;
            fh_nxt           = fh_inc;
            bh_nxt           = bh_inc;
            bc_nxt           = bc_r - CW'(1);
          end else begin
            res.popped_value = f_rd_data;
            f_wr_en          = 1'b1;
            f_wr_data        = b_rd_data;
            fh_nxt           = fh_inc;
            bh_nxt           = bh_inc;
            bc_nxt           = bc_r - CW'(1);
          end
        end
        OP_POP_MIDDLE: begin
          if (empty) begin
            res.popped_value = EMPTY_VALUE;
            res.status       = ST_EMPTY;
          end else if (eq) begin
            res.popped_value = f_rd_data;
            fc_nxt           = fc_r - CW'(1);
          end else begin
            // The first back entry is popped straight off the back head.
            res.popped_value = b_rd_data;
            bh_nxt           = bh_inc;
            bc_nxt           = bc_r - CW'(1);
          end
        end
        OP_POP_BACK: begin
          if (empty) begin
            res.popped_value = EMPTY_VALUE;
            res.status       = ST_EMPTY;
          end else if (eq) begin
            res.popped_value = b_rd_data;
            b_wr_en          = 1'b1;
            b_wr_addr        = b_prev;
            b_wr_data        = f_rd_data;
            bh_nxt           = b_prev;
            fc_nxt           = fc_r - CW'(1);
          end else begin
            res.popped_value = b_rd_data;
            bc_nxt           = bc_r - CW'(1);
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    state_nxt     = state_r;
    op_nxt        = op_r;
    value_nxt     = value_r;
    out_valid_nxt = out_valid_r;
    out_nxt       = out_r;
    if (accept) begin
      state_nxt = S_EXEC;
      op_nxt    = in_data.op;
      value_nxt = in_data.value;
    end
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
    if (finish) begin
      state_nxt     = S_IDLE;
      out_valid_nxt = 1'b1;
      out_nxt       = res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      fh_r        <= '0;
      fc_r        <= '0;
      bh_r        <= '0;
      bc_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      fh_r        <= fh_nxt;
      fc_r        <= fc_nxt;
      bh_r        <= bh_nxt;
      bc_r        <= bc_nxt;
      out_valid_r <= out_valid_nxt;
    end
    op_r    <= op_nxt;
    value_r <= value_nxt;
    out_r   <= out_nxt;
  end

  a_balance: assert property (@(posedge clk) disable iff (!rst_n)
    (bc_r == fc_r) || (bc_r == fc_r + CW'(1)))
    else $error("queue halves out of balance");

  a_capacity: assert property (@(posedge clk) disable iff (!rst_n)
    total <= TW'(CAPACITY))
    else $error("queue holds more than its capacity");

  a_push_grows: assert property (@(posedge clk) disable iff (!rst_n)
    (finish && res.status == ST_OK &&
     (op_r == OP_PUSH_FRONT || op_r == OP_PUSH_MIDDLE || op_r == OP_PUSH_BACK))
    |=> total == $past(total) + TW'(1))
    else $error("accepted push did not add one entry");

  a_pop_shrinks: assert property (@(posedge clk) disable iff (!rst_n)
    (finish && res.status == ST_OK &&
     (op_r == OP_POP_FRONT || op_r == OP_POP_MIDDLE || op_r == OP_POP_BACK))
    |=> total == $past(total) - TW'(1))
    else $error("successful pop did not remove one entry");

  a_error_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (finish && res.status != ST_OK) |=> $stable(fc_r) && $stable(bc_r))
    else $error("rejected request changed the queue");

endmodule
